>>> src/eta_pkg.sv
// package for the embedding table with adagrad update
// types, constants and opcodes shared by eta_alu and the top level; no dependencies
`timescale 1ns / 1ps
package eta_pkg;
  localparam int DefEntries = 1024;
  localparam int DefDim = 64;
  localparam int EntryW = 10;
  localparam int ElemW = 6;
  localparam int RateW = 25;
  localparam logic [RateW-1:0] RateReset = 25'd16777;
  localparam logic [31:0] AccReset = 32'd17;
  localparam logic [31:0] S32Max = 32'h7FFF_FFFF;
  localparam logic [31:0] S32Min = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_READ = 2'd1,
    OP_ADD  = 2'd2,
    OP_UPD  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [EntryW-1:0] entry_index;
    logic [ElemW-1:0]  element_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               saturated;
  } out_item_t;

  // request to the shared iterative unit
  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
    logic [56:0] dividend;
  } alu_req_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                          output logic ovf);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    ovf = (s[32] != s[31]);
    sat_add = ovf ? (s[32] ? S32Min : S32Max) : s[31:0];
  endfunction
endpackage

>>> src/eta_ram.sv
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module eta_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> src/eta_alu.sv
// shared iterative unit: 64-bit integer square root then restoring division,
// one bit per cycle each; depends on eta_pkg
`timescale 1ns / 1ps
module eta_alu (
  input  logic            clk,
  input  logic            rst_n,
  input  eta_pkg::alu_req_t req,
  output logic            done,
  output logic [31:0]     root,
  output logic            root_sat,
  output logic [31:0]     quot
);
  import eta_pkg::*;
  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_SQRT = 3'b010,
    A_DIV  = 3'b100
  } alu_st_t;
  alu_st_t st_r, st_nxt;
  logic [63:0] x_r, x_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [56:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [56:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [64:0] trial;
  logic [33:0] rtrial;
  logic        done_nxt;
  logic        sat_r, sat_nxt;

  always_comb begin
    st_nxt = st_r; x_nxt = x_r; r_nxt = r_r; bit_nxt = bit_r;
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; q_nxt = q_r;
    cnt_nxt = cnt_r; done_nxt = 1'b0; sat_nxt = sat_r;
    trial = {1'b0, r_r} + {1'b0, bit_r};
    rtrial = {rem_r, num_r[56]} - {2'b00, den_r};
    case (st_r)
      A_IDLE: if (req.start) begin
        x_nxt = req.radicand; r_nxt = '0; bit_nxt = 64'h4000_0000_0000_0000;
        num_nxt = req.dividend; st_nxt = A_SQRT; cnt_nxt = 6'd31;
      end
      A_SQRT: begin
        if ({1'b0, x_r} >= trial) begin
          x_nxt = x_r - trial[63:0];
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (cnt_r == 6'd0) begin
          // saturate root to signed range
          sat_nxt = (r_nxt > {32'd0, S32Max});
          den_nxt = sat_nxt ? S32Max : r_nxt[31:0];
          rem_nxt = '0; q_nxt = '0; cnt_nxt = 6'd56; st_nxt = A_DIV;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      A_DIV: begin
        if (!rtrial[33]) begin
          rem_nxt = rtrial[32:0];
        end else begin
          rem_nxt = {rem_r[31:0], num_r[56]};
        end
        q_nxt = {q_r[55:0], ~rtrial[33]};
        num_nxt = {num_r[55:0], 1'b0};
        if (cnt_r == 6'd0) begin
          st_nxt = A_IDLE; done_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE; done <= 1'b0;
    end else begin
      st_r <= st_nxt; done <= done_nxt;
    end
    x_r <= x_nxt; r_r <= r_nxt; bit_r <= bit_nxt; num_r <= num_nxt;
    den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt; cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
  end

  // quotient bounded by rate*|g|/den with den >= 1: zero divisor yields zero
  assign root = den_r;
  assign root_sat = sat_r;
  assign quot = (den_r == 32'd0) ? 32'd0
              : ((|q_r[56:32]) ? 32'hFFFF_FFFF : q_r[31:0]);
endmodule

>>> src/embedding_table_adagrad.sv
// top level of the embedding table with adagrad update
// depends on eta_pkg, eta_ram and eta_alu
`timescale 1ns / 1ps
// One transaction is taken when start is high and busy is low; exactly one result
// follows with out_valid high for one cycle, which the receiver cannot stall.
// Load, read and gradient add pass through S_RD and S_EXEC to a registered result
// (memory read then write); the next transaction can be taken in the result cycle.
// Apply update walks every entry, reading its mark in S_SCAN and testing it in S_SCHK;
// each element of a marked entry passes S_URD, S_UWAIT, S_UMUL, S_UALU (shared square
// root, 32 steps, then divider, 57 steps) and S_UWR. After reset, busy stays high while
// a clearing pass over the ENTRIES*DIM cells writes gradient, accumulator and marks.
module embedding_table_adagrad #(
  parameter int ENTRIES = eta_pkg::DefEntries,
  parameter int DIM = eta_pkg::DefDim
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  eta_pkg::in_item_t            in_item,
  output logic                         out_valid,
  output eta_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [eta_pkg::RateW-1:0]    cfg_wdata
);
  import eta_pkg::*;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW = $clog2(ENTRIES * DIM);
  localparam int Cells = ENTRIES * DIM;

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD    = 11'b00000000100,
    S_EXEC  = 11'b00000001000,
    S_SCAN  = 11'b00000010000,
    S_SCHK  = 11'b00000100000,
    S_URD   = 11'b00001000000,
    S_UWAIT = 11'b00010000000,
    S_UMUL  = 11'b00100000000,
    S_UALU  = 11'b01000000000,
    S_UWR   = 11'b10000000000
  } st_t;
  st_t st_r, st_nxt;

  logic [RateW-1:0] rate_r;
  in_item_t item_r, item_nxt;
  logic mark_we, mark_wd, mark_rd;
  logic [EW-1:0] mark_addr;
  logic [EW:0] ent_r, ent_nxt;
  logic [DW:0] elt_r, elt_nxt;
  logic [CW:0] clr_r, clr_nxt;
  logic flag_r, flag_nxt;
  logic ok;
  logic [CW-1:0] addr;
  logic [CW-1:0] item_addr, sweep_addr;
  logic emb_we, grad_we, acc_we;
  logic [31:0] emb_wd, grad_wd, acc_wd, emb_rd, grad_rd, acc_rd;
  logic [63:0] asq_r, gsq_r;
  logic [31:0] am, gm;
  logic [56:0] prod_r;
  alu_req_t req;
  logic alu_done, root_sat;
  logic [31:0] root, quot;
  logic ovf;
  logic [31:0] sum;
  out_item_t res_nxt;
  logic res_v_nxt;

  assign ok = ({22'd0, item_r.entry_index} < 32'(ENTRIES))
           && ({26'd0, item_r.element_index} < 32'(DIM));
  assign item_addr = CW'(item_r.entry_index) * CW'(DIM) + CW'(item_r.element_index);
  assign sweep_addr = CW'(ent_r[EW-1:0]) * CW'(DIM) + CW'(elt_r[DW-1:0]);

  eta_ram #(.Width(32), .Depth(Cells)) u_emb (
    .clk(clk), .we(emb_we), .addr(addr), .wdata(emb_wd), .rdata(emb_rd));
  eta_ram #(.Width(32), .Depth(Cells)) u_grad (
    .clk(clk), .we(grad_we), .addr(addr), .wdata(grad_wd), .rdata(grad_rd));
  eta_ram #(.Width(32), .Depth(Cells)) u_acc (
    .clk(clk), .we(acc_we), .addr(addr), .wdata(acc_wd), .rdata(acc_rd));
  eta_ram #(.Width(1), .Depth(ENTRIES)) u_mark (
    .clk(clk), .we(mark_we), .addr(mark_addr), .wdata(mark_wd), .rdata(mark_rd));

  eta_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req),
    .done(alu_done), .root(root), .root_sat(root_sat), .quot(quot));

  assign am = acc_rd[31] ? (~acc_rd + 32'd1) : acc_rd;
  assign gm = grad_rd[31] ? (~grad_rd + 32'd1) : grad_rd;

  always_comb begin
    st_nxt = st_r; item_nxt = item_r; ent_nxt = ent_r;
    elt_nxt = elt_r; clr_nxt = clr_r; flag_nxt = flag_r;
    emb_we = 1'b0; grad_we = 1'b0; acc_we = 1'b0;
    mark_we = 1'b0; mark_wd = 1'b0; mark_addr = ent_r[EW-1:0];
    emb_wd = item_r.value; grad_wd = 32'd0; acc_wd = AccReset;
    addr = item_addr; req = '0; res_v_nxt = 1'b0; res_nxt = '0;
    sum = 32'd0; ovf = 1'b0;
    case (st_r)
      S_CLR: begin
        addr = clr_r[CW-1:0]; grad_we = 1'b1; acc_we = 1'b1;
        mark_addr = clr_r[EW-1:0]; mark_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (CW+1)'(Cells - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        item_nxt = in_item; st_nxt = S_RD;
      end
      S_RD: begin
        if (item_r.operation == OP_UPD) begin
          ent_nxt = '0; flag_nxt = 1'b0; st_nxt = S_SCAN;
        end else begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // memory read data now valid
        st_nxt = S_IDLE; res_v_nxt = 1'b1;
        case (item_r.operation)
          OP_LOAD: emb_we = ok;
          OP_READ: res_nxt.read_value = ok ? emb_rd : 32'd0;
          OP_ADD: begin
            sum = sat_add(grad_rd, item_r.value, ovf);
            grad_wd = sum; grad_we = ok;
            res_nxt.saturated = ok & ovf;
            mark_addr = item_r.entry_index[EW-1:0]; mark_wd = 1'b1; mark_we = ok;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // mark of the current entry is read here and tested in the next cycle
        if (ent_r == (EW+1)'(ENTRIES)) begin
          st_nxt = S_IDLE; res_v_nxt = 1'b1; res_nxt.saturated = flag_r;
        end else begin
          st_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (mark_rd) begin
          elt_nxt = '0; st_nxt = S_URD;
        end else begin
          ent_nxt = ent_r + 1'b1; st_nxt = S_SCAN;
        end
      end
      S_URD: begin addr = sweep_addr; st_nxt = S_UWAIT; end
      S_UWAIT: begin addr = sweep_addr; st_nxt = S_UMUL; end
      S_UMUL: begin
        addr = sweep_addr; req.start = 1'b1;
        req.radicand = asq_r + gsq_r; req.dividend = prod_r;
        st_nxt = S_UALU;
      end
      S_UALU: begin
        addr = sweep_addr;
        if (alu_done) st_nxt = S_UWR;
      end
      S_UWR: begin
        addr = sweep_addr;
        acc_wd = root; acc_we = 1'b1; grad_wd = 32'd0; grad_we = 1'b1;
        if (grad_rd[31]) sum = sat_add(emb_rd, quot, ovf);
        else sum = sat_add(emb_rd, ~quot + 32'd1, ovf);
        // quotient above the signed range clamps the result, except 2^31 with a non-negative gradient
        if (quot[31] && (quot != 32'h8000_0000 || grad_rd[31])) begin
          sum = grad_rd[31] ? S32Max : S32Min; ovf = 1'b1;
          if (!grad_rd[31] && emb_rd[31] == 1'b0 && quot == 32'h8000_0000) ovf = 1'b0;
        end
        emb_wd = sum; emb_we = 1'b1;
        flag_nxt = flag_r | root_sat | ovf;
        if (elt_r == (DW+1)'(DIM - 1)) begin
          mark_wd = 1'b0; mark_we = 1'b1;
          ent_nxt = ent_r + 1'b1; st_nxt = S_SCAN;
        end else begin
          elt_nxt = elt_r + 1'b1; st_nxt = S_URD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // one multiplier stage before the iterative unit
  always_ff @(posedge clk) begin
    asq_r <= 64'(am) * 64'(am);
    gsq_r <= 64'(gm) * 64'(gm);
    prod_r <= 57'(rate_r) * 57'(gm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; rate_r <= RateReset; clr_r <= '0;
      out_valid <= 1'b0; flag_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt;
      out_valid <= res_v_nxt; flag_r <= flag_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
    end
    item_r <= item_nxt; ent_r <= ent_nxt; elt_r <= elt_nxt;
    out_item <= res_nxt;
  end

  assign busy = (st_r != S_IDLE);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == S_IDLE)) else $error("result outside idle");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (st_r == S_RD)) else $error("transaction not taken");
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |-> (out_item.read_value == 32'sd0))
    else $error("flag with read data");
endmodule
